/* rtl/vles_pkg.sv */
`timescale 1ns / 1ps

package vles_pkg;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_VINT    = 3'd1,
        PH_HINT    = 3'd2,
        PH_DISPLAY = 3'd3,
        PH_END     = 3'd4
    } t_phase;

    typedef enum logic {
        CMD_EVENT    = 1'b0,
        CMD_DMA_LOAD = 1'b1
    } t_cmd;

    localparam logic [2:0] CFG_VIS_START      = 3'd0;
    localparam logic [2:0] CFG_VIS_END        = 3'd1;
    localparam logic [2:0] CFG_TOTAL_LINES    = 3'd2;
    localparam logic [2:0] CFG_HINT_ENABLE    = 3'd3;
    localparam logic [2:0] CFG_VINT_ENABLE    = 3'd4;
    localparam logic [2:0] CFG_DISPLAY_ENABLE = 3'd5;
    localparam logic [2:0] CFG_HINT_RELOAD    = 3'd6;
    localparam logic [2:0] CFG_WIDE_MODE      = 3'd7;

    localparam logic [8:0] VIS_START_RESET   = 9'd1;
    localparam logic [8:0] VIS_END_RESET     = 9'd225;
    localparam logic [8:0] TOTAL_LINES_RESET = 9'd262;
    localparam logic [7:0] HINT_RELOAD_RESET = 8'd255;

    localparam logic [16:0] DMA_BLANK_WIDE    = 17'd205;
    localparam logic [16:0] DMA_BLANK_NARROW  = 17'd167;
    localparam logic [16:0] DMA_ACTIVE_WIDE   = 17'd18;
    localparam logic [16:0] DMA_ACTIVE_NARROW = 17'd16;

    typedef struct packed {
        logic [8:0] vis_start_line;
        logic [8:0] vis_end_line;
        logic [8:0] total_lines;
        logic       hint_enable;
        logic       vint_enable;
        logic       display_enable;
        logic [7:0] hint_reload;
        logic       wide_mode;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [8:0]  line;
        logic        vblank;
        logic        hblank;
        logic [7:0]  hint_counter;
        logic [16:0] dma_remaining;
        logic        dma_busy;
    } t_state;

    typedef struct packed {
        logic [2:0] event_phase;
        logic [8:0] line_number;
        logic       vblank;
        logic       hblank;
        logic       vsync_pulse;
        logic       vint_request;
        logic       hint_request;
        logic       render_request;
        logic [8:0] render_row;
        logic       line_end;
        logic       field_end;
        logic       dma_busy;
    } t_result;

endpackage

/* rtl/video_line_event_sequencer.sv */
`timescale 1ns / 1ps

// Scanline event sequencer. Each command beat on the input channel yields exactly one
// result beat: a next-event command steps the line through its five phases (start,
// vertical interrupt, horizontal interrupt, display, end), and a DMA load command sets
// the outstanding byte count. The block takes one beat per clock cycle while the skid
// register is empty and registers its result; a two-entry output buffer (result
// register plus skid register) lets input continue for one beat while output stalls.
// Configuration registers may be written only while no result is outstanding.

module video_line_event_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [16:0] i_dma_count,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_event_phase,
    output logic [8:0]  o_line_number,
    output logic        o_vblank,
    output logic        o_hblank,
    output logic        o_vsync_pulse,
    output logic        o_vint_request,
    output logic        o_hint_request,
    output logic        o_render_request,
    output logic [8:0]  o_render_row,
    output logic        o_line_end,
    output logic        o_field_end,
    output logic        o_dma_busy,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    vles_pkg::t_cfg    r_cfg;
    vles_pkg::t_state  r_state;
    vles_pkg::t_state  n_state;
    vles_pkg::t_result n_result;
    vles_pkg::t_result r_head;
    vles_pkg::t_result r_skid;
    logic              r_head_valid;
    logic              r_skid_valid;
    logic              push;
    logic              pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_skid_valid;
    assign push        = i_in_valid && o_in_ready;
    assign pop         = r_head_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vis_start_line <= vles_pkg::VIS_START_RESET;
            r_cfg.vis_end_line   <= vles_pkg::VIS_END_RESET;
            r_cfg.total_lines    <= vles_pkg::TOTAL_LINES_RESET;
            r_cfg.hint_enable    <= 1'b0;
            r_cfg.vint_enable    <= 1'b0;
            r_cfg.display_enable <= 1'b0;
            r_cfg.hint_reload    <= vles_pkg::HINT_RELOAD_RESET;
            r_cfg.wide_mode      <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                vles_pkg::CFG_VIS_START:      r_cfg.vis_start_line <= i_cfg_data;
                vles_pkg::CFG_VIS_END:        r_cfg.vis_end_line   <= i_cfg_data;
                vles_pkg::CFG_TOTAL_LINES:    r_cfg.total_lines    <= i_cfg_data;
                vles_pkg::CFG_HINT_ENABLE:    r_cfg.hint_enable    <= i_cfg_data[0];
                vles_pkg::CFG_VINT_ENABLE:    r_cfg.vint_enable    <= i_cfg_data[0];
                vles_pkg::CFG_DISPLAY_ENABLE: r_cfg.display_enable <= i_cfg_data[0];
                vles_pkg::CFG_HINT_RELOAD:    r_cfg.hint_reload    <= i_cfg_data[7:0];
                vles_pkg::CFG_WIDE_MODE:      r_cfg.wide_mode      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    vles_step u_step (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_cmd       (i_cmd),
        .i_dma_count (i_dma_count),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= vles_pkg::PH_START;
            r_state.line          <= '0;
            r_state.vblank        <= 1'b0;
            r_state.hblank        <= 1'b0;
            r_state.hint_counter  <= '0;
            r_state.dma_remaining <= '0;
            r_state.dma_busy      <= 1'b0;
        end else if (push) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_head_valid || pop) begin
            r_head_valid <= r_skid_valid || push;
            r_skid_valid <= 1'b0;
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_head_valid || pop) begin
            r_head <= r_skid_valid ? r_skid : n_result;
        end else if (push) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid      = r_head_valid;
    assign o_event_phase    = r_head.event_phase;
    assign o_line_number    = r_head.line_number;
    assign o_vblank         = r_head.vblank;
    assign o_hblank         = r_head.hblank;
    assign o_vsync_pulse    = r_head.vsync_pulse;
    assign o_vint_request   = r_head.vint_request;
    assign o_hint_request   = r_head.hint_request;
    assign o_render_request = r_head.render_request;
    assign o_render_row     = r_head.render_row;
    assign o_line_end       = r_head.line_end;
    assign o_field_end      = r_head.field_end;
    assign o_dma_busy       = r_head.dma_busy;

    a_skid_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_head_valid)
        else $error("skid register holds a beat while the result register is empty");

    a_stall_keeps_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head_valid && !i_out_ready) |=> (r_head_valid && $stable(r_head)))
        else $error("stalled result changed");

    a_field_end_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_field_end) |-> (o_line_end && o_line_number == 9'd0))
        else $error("field end without a line restart");

    a_hint_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hint_request) |-> (o_event_phase == vles_pkg::PH_HINT))
        else $error("horizontal interrupt outside its phase");

    a_row_only_when_drawn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_render_request) |-> (o_render_row == 9'd0))
        else $error("render row set without a render request");

endmodule

/* rtl/vles_step.sv */
`timescale 1ns / 1ps

module vles_step (
    input  vles_pkg::t_cfg    i_cfg,
    input  vles_pkg::t_state  i_state,
    input  logic              i_cmd,
    input  logic [16:0]       i_dma_count,
    output vles_pkg::t_state  o_state,
    output vles_pkg::t_result o_result
);

    logic [9:0]  line_p1;
    logic        at_pre_start;
    logic        in_vis;
    logic        in_win;
    logic [7:0]  hint_cnt;
    logic [16:0] dma_rate;
    logic [8:0]  line_inc;

    assign line_p1      = {1'b0, i_state.line} + 10'd1;
    assign at_pre_start = (i_cfg.vis_start_line != 9'd0)
                          && (line_p1 == {1'b0, i_cfg.vis_start_line});
    assign in_vis = (i_state.line >= i_cfg.vis_start_line)
                    && (i_state.line < i_cfg.vis_end_line);
    assign in_win = (line_p1 >= {1'b0, i_cfg.vis_start_line})
                    && (line_p1 < {1'b0, i_cfg.vis_end_line});
    assign line_inc = line_p1[8:0];

    always_comb begin
        if (i_state.vblank || !i_cfg.display_enable) begin
            dma_rate = i_cfg.wide_mode ? vles_pkg::DMA_BLANK_WIDE
                                       : vles_pkg::DMA_BLANK_NARROW;
        end else begin
            dma_rate = i_cfg.wide_mode ? vles_pkg::DMA_ACTIVE_WIDE
                                       : vles_pkg::DMA_ACTIVE_NARROW;
        end
    end

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        hint_cnt = i_state.hint_counter;
        o_result.event_phase = i_state.phase;

        if (i_cmd == vles_pkg::CMD_DMA_LOAD) begin
            o_state.dma_remaining = i_dma_count;
            o_state.dma_busy      = (i_dma_count != 17'd0);
        end else begin
            unique case (i_state.phase)
                vles_pkg::PH_VINT: begin
                    if (i_state.line == i_cfg.vis_end_line) begin
                        o_state.vblank        = 1'b1;
                        o_result.vsync_pulse  = 1'b1;
                        o_result.vint_request = i_cfg.vint_enable;
                    end
                    o_state.phase = vles_pkg::PH_HINT;
                end
                vles_pkg::PH_HINT: begin
                    if (in_vis) begin
                        o_state.hblank = 1'b1;
                    end
                    if (at_pre_start || (i_state.line > i_cfg.vis_end_line)) begin
                        hint_cnt = i_cfg.hint_reload;
                    end
                    if (i_cfg.hint_enable) begin
                        if (hint_cnt == 8'd0) begin
                            hint_cnt              = i_cfg.hint_reload;
                            o_result.hint_request = in_win;
                        end else begin
                            hint_cnt = hint_cnt - 8'd1;
                        end
                    end
                    o_state.hint_counter = hint_cnt;
                    if (i_state.dma_remaining != 17'd0) begin
                        if (i_state.dma_remaining <= dma_rate) begin
                            o_state.dma_remaining = '0;
                            o_state.dma_busy      = 1'b0;
                        end else begin
                            o_state.dma_remaining = i_state.dma_remaining - dma_rate;
                        end
                    end
                    o_state.phase = vles_pkg::PH_DISPLAY;
                end
                vles_pkg::PH_DISPLAY: begin
                    if (in_win) begin
                        o_result.render_request = 1'b1;
                        o_result.render_row = i_state.line - i_cfg.vis_start_line + 9'd1;
                    end
                    o_state.phase = vles_pkg::PH_END;
                end
                vles_pkg::PH_END: begin
                    if (in_vis) begin
                        o_state.hblank = 1'b0;
                    end
                    o_result.line_end = 1'b1;
                    if (line_inc == i_cfg.total_lines) begin
                        o_result.field_end = 1'b1;
                        o_state.line       = '0;
                    end else begin
                        o_state.line = line_inc;
                    end
                    o_state.phase = vles_pkg::PH_START;
                end
                default: begin
                    o_result.event_phase = vles_pkg::PH_START;
                    if (at_pre_start) begin
                        o_state.vblank = 1'b0;
                    end
                    o_state.phase = vles_pkg::PH_VINT;
                end
            endcase
        end

        o_result.line_number = o_state.line;
        o_result.vblank      = o_state.vblank;
        o_result.hblank      = o_state.hblank;
        o_result.dma_busy    = o_state.dma_busy;
    end

endmodule

/* tb/sv/video_line_event_checker.sv */
`timescale 1ns / 1ps

module video_line_event_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_cmd,
    input  logic [16:0] i_dma_count,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_event_phase,
    input  logic [8:0]  i_line_number,
    input  logic        i_vblank,
    input  logic        i_hblank,
    input  logic        i_vsync_pulse,
    input  logic        i_vint_request,
    input  logic        i_hint_request,
    input  logic        i_render_request,
    input  logic [8:0]  i_render_row,
    input  logic        i_line_end,
    input  logic        i_field_end,
    input  logic        i_dma_busy,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    import vles_pkg::*;

    t_cfg        regs;
    t_phase      cur_phase;
    logic [8:0]  cur_line;
    logic        vblank_q;
    logic        hblank_q;
    logic [7:0]  hint_count;
    logic [16:0] dma_left;
    logic        busy_q;
    t_result     expected_results[$];
    int          fails = 0;

    assign o_fail_count = fails;

    function automatic t_result step_line_event(input t_cmd c, input logic [16:0] cnt);
        t_result     r;
        t_phase      ev;
        int          ln;
        int          vs;
        int          ve;
        bit          in_vis;
        bit          in_win;
        logic [16:0] rate;
        r = '0;
        ev = (cur_phase > PH_END) ? PH_START : cur_phase;
        ln = cur_line;
        vs = regs.vis_start_line;
        ve = regs.vis_end_line;
        in_vis = (ln >= vs) && (ln < ve);
        in_win = (ln >= vs - 1) && (ln < ve - 1);
        if (c == CMD_DMA_LOAD) begin
            dma_left = cnt;
            busy_q = (cnt != '0);
            ev = cur_phase;
        end else begin
            case (ev)
                PH_VINT: begin
                    if (ln == ve) begin
                        vblank_q = 1'b1;
                        r.vsync_pulse = 1'b1;
                        r.vint_request = regs.vint_enable;
                    end
                end
                PH_HINT: begin
                    if (in_vis)
                        hblank_q = 1'b1;
                    if (ln == vs - 1 || ln > ve)
                        hint_count = regs.hint_reload;
                    if (regs.hint_enable) begin
                        if (hint_count == 8'd0) begin
                            hint_count = regs.hint_reload;
                            r.hint_request = in_win;
                        end else begin
                            hint_count = hint_count - 8'd1;
                        end
                    end
                    if (dma_left != '0) begin
                        if (vblank_q || !regs.display_enable)
                            rate = regs.wide_mode ? DMA_BLANK_WIDE : DMA_BLANK_NARROW;
                        else
                            rate = regs.wide_mode ? DMA_ACTIVE_WIDE : DMA_ACTIVE_NARROW;
                        if (dma_left <= rate) begin
                            dma_left = '0;
                            busy_q = 1'b0;
                        end else begin
                            dma_left = dma_left - rate;
                        end
                    end
                end
                PH_DISPLAY: begin
                    if (in_win) begin
                        r.render_request = 1'b1;
                        r.render_row = cur_line - regs.vis_start_line + 9'd1;
                    end
                end
                PH_END: begin
                    if (in_vis)
                        hblank_q = 1'b0;
                    r.line_end = 1'b1;
                    cur_line = cur_line + 9'd1;
                    if (cur_line == regs.total_lines) begin
                        r.field_end = 1'b1;
                        cur_line = '0;
                    end
                end
                default: begin
                    if (ln == vs - 1)
                        vblank_q = 1'b0;
                end
            endcase
            cur_phase = (ev == PH_END) ? PH_START : t_phase'(ev + 3'd1);
        end
        r.event_phase = ev;
        r.line_number = cur_line;
        r.vblank = vblank_q;
        r.hblank = hblank_q;
        r.dma_busy = busy_q;
        return r;
    endfunction

    task automatic check_field(input string fld, input int unsigned want, input int unsigned got);
        if (want != got) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            regs.vis_start_line = VIS_START_RESET;
            regs.vis_end_line = VIS_END_RESET;
            regs.total_lines = TOTAL_LINES_RESET;
            regs.hint_enable = 1'b0;
            regs.vint_enable = 1'b0;
            regs.display_enable = 1'b0;
            regs.hint_reload = HINT_RELOAD_RESET;
            regs.wide_mode = 1'b0;
            cur_phase = PH_START;
            cur_line = '0;
            vblank_q = 1'b0;
            hblank_q = 1'b0;
            hint_count = '0;
            dma_left = '0;
            busy_q = 1'b0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_VIS_START:      regs.vis_start_line = i_cfg_data;
                    CFG_VIS_END:        regs.vis_end_line = i_cfg_data;
                    CFG_TOTAL_LINES:    regs.total_lines = i_cfg_data;
                    CFG_HINT_ENABLE:    regs.hint_enable = i_cfg_data[0];
                    CFG_VINT_ENABLE:    regs.vint_enable = i_cfg_data[0];
                    CFG_DISPLAY_ENABLE: regs.display_enable = i_cfg_data[0];
                    CFG_HINT_RELOAD:    regs.hint_reload = i_cfg_data[7:0];
                    default:            regs.wide_mode = i_cfg_data[0];
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result beat, expected none, actual phase %0d line %0d",
                             $time, i_event_phase, i_line_number);
                end else begin
                    want = expected_results.pop_front();
                    check_field("event_phase", want.event_phase, i_event_phase);
                    check_field("line_number", want.line_number, i_line_number);
                    check_field("vblank", want.vblank, i_vblank);
                    check_field("hblank", want.hblank, i_hblank);
                    check_field("vsync_pulse", want.vsync_pulse, i_vsync_pulse);
                    check_field("vint_request", want.vint_request, i_vint_request);
                    check_field("hint_request", want.hint_request, i_hint_request);
                    check_field("render_request", want.render_request, i_render_request);
                    check_field("render_row", want.render_row, i_render_row);
                    check_field("line_end", want.line_end, i_line_end);
                    check_field("field_end", want.field_end, i_field_end);
                    check_field("dma_busy", want.dma_busy, i_dma_busy);
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(step_line_event(t_cmd'(i_cmd), i_dma_count));
        end
        o_pending <= expected_results.size();
    end

endmodule

/* tb/sv/video_line_event_sequencer_tb.sv */
`timescale 1ns / 1ps

module video_line_event_sequencer_tb;
    import vles_pkg::*;

    localparam int LONG_HOLD   = 80;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        cmd_bit = 1'b0;
    logic [16:0] dma_count = '0;
    logic        out_ready = 1'b1;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [8:0]  cfg_data = '0;

    logic        in_ready;
    logic        out_valid;
    logic [2:0]  event_phase;
    logic [8:0]  line_number;
    logic        vblank;
    logic        hblank;
    logic        vsync_pulse;
    logic        vint_request;
    logic        hint_request;
    logic        render_request;
    logic [8:0]  render_row;
    logic        line_end;
    logic        field_end;
    logic        dma_busy;
    logic        cfg_ready;

    int fail_count;
    int pending;
    int cycles = 0;
    int hold_asked = 0;
    int hold_done = 0;
    bit idle_on = 1'b1;

    always #2 i_clk = ~i_clk;

    video_line_event_sequencer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_cmd            (cmd_bit),
        .i_dma_count      (dma_count),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_event_phase    (event_phase),
        .o_line_number    (line_number),
        .o_vblank         (vblank),
        .o_hblank         (hblank),
        .o_vsync_pulse    (vsync_pulse),
        .o_vint_request   (vint_request),
        .o_hint_request   (hint_request),
        .o_render_request (render_request),
        .o_render_row     (render_row),
        .o_line_end       (line_end),
        .o_field_end      (field_end),
        .o_dma_busy       (dma_busy),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    video_line_event_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_cmd            (cmd_bit),
        .i_dma_count      (dma_count),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_event_phase    (event_phase),
        .i_line_number    (line_number),
        .i_vblank         (vblank),
        .i_hblank         (hblank),
        .i_vsync_pulse    (vsync_pulse),
        .i_vint_request   (vint_request),
        .i_hint_request   (hint_request),
        .i_render_request (render_request),
        .i_render_row     (render_row),
        .i_line_end       (line_end),
        .i_field_end      (field_end),
        .i_dma_busy       (dma_busy),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("video_line_event_sequencer test failed");
            $finish;
        end
    end

    // Result side: a requested long hold takes priority over the random stalls.
    initial begin
        int burst;
        forever begin
            @(posedge i_clk);
            if (hold_asked != hold_done) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
                hold_done = hold_done + 1;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                out_ready <= 1'b0;
                burst = $urandom_range(1, 15);
                repeat (burst - 1) @(posedge i_clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input t_cmd c, input logic [16:0] cnt);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        cmd_bit <= c;
        dma_count <= cnt;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic send_events(input int n);
        repeat (n) send_item(CMD_EVENT, 17'($urandom));
    endtask

    task automatic send_random_item();
        logic [16:0] cnt;
        int          pick;
        pick = $urandom_range(0, 3);
        if (pick == 0)
            cnt = 17'($urandom_range(0, 220));
        else if (pick == 1)
            cnt = 17'h1FFFF;
        else
            cnt = 17'($urandom);
        send_item(($urandom_range(0, 7) == 0) ? CMD_DMA_LOAD : CMD_EVENT, cnt);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [8:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
    endtask

    task automatic apply_settings(input logic [8:0] vs, input logic [8:0] ve,
                                  input logic [8:0] tl, input logic he, input logic vie,
                                  input logic de, input logic [7:0] hr, input logic wm);
        write_reg(CFG_VIS_START, vs);
        write_reg(CFG_VIS_END, ve);
        write_reg(CFG_TOTAL_LINES, tl);
        write_reg(CFG_HINT_ENABLE, {8'd0, he});
        write_reg(CFG_VINT_ENABLE, {8'd0, vie});
        write_reg(CFG_DISPLAY_ENABLE, {8'd0, de});
        write_reg(CFG_HINT_RELOAD, {1'b0, hr});
        write_reg(CFG_WIDE_MODE, {8'd0, wm});
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_settings();
        logic [8:0] vs;
        logic [8:0] ve;
        logic [8:0] tl;
        logic [7:0] hr;
        vs = ($urandom_range(0, 5) == 0) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(0, 10));
        ve = ($urandom_range(0, 5) == 0) ? 9'($urandom_range(1, 511)) : 9'($urandom_range(1, 14));
        tl = ($urandom_range(0, 5) == 0) ? 9'($urandom_range(2, 511)) : 9'($urandom_range(2, 18));
        hr = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
        apply_settings(vs, ve, tl, 1'($urandom), 1'($urandom), 1'($urandom), hr, 1'($urandom));
    endtask

    initial begin
        int n;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(CMD_DMA_LOAD, 17'h1FFFF);
        send_events(6);
        send_item(CMD_DMA_LOAD, 17'd0);
        send_item(CMD_DMA_LOAD, 17'd167);
        send_events(5);
        wait_drained();

        apply_settings(9'd0, 9'd2, 9'd4, 1'b1, 1'b1, 1'b1, 8'd0, 1'b1);
        send_item(CMD_DMA_LOAD, 17'd19);
        send_events(20);
        wait_drained();

        for (n = 0; n < 9; n++) begin
            if (n == 0)
                apply_settings(9'd511, 9'd511, 9'd511, 1'b1, 1'b1, 1'b1, 8'd255, 1'b1);
            else if (n == 1)
                apply_settings(9'd0, 9'd1, 9'd2, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0);
            else
                pick_settings();
            if (n == 4) begin
                idle_on = 1'b0;
                hold_asked = hold_asked + 1;
            end
            repeat (62) send_random_item();
            idle_on = 1'b1;
            wait_drained();
        end

        idle_on = 1'b0;
        pick_settings();
        repeat (60) send_random_item();
        wait_drained();
        repeat (8) @(posedge i_clk);

        if (fail_count == 0)
            $display("video_line_event_sequencer test passed");
        else
            $display("video_line_event_sequencer test failed");
        $finish;
    end

endmodule
